// ===== sv/ordered_list_engine_core_macros.svh =====
// Assertion macros for the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OLEC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OLEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/olec_pkg.sv =====
package olec_pkg;

    // Fixed field widths of the request and result beats
    localparam int REQ_W   = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int ERR_W   = 3;
    localparam int DATA_W  = 32;
    localparam int FOUND_W = 5;
    localparam int COUNT_W = 5;

    // Index width covering every cell index, count and position
    localparam int IDX_W = 9;

    // Find scans match flags in groups of this size
    localparam int GRP     = 8;
    localparam int GRP_LOG = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET    = 3'd0,
        REQ_SET    = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_PUSH   = 3'd4,
        REQ_POP    = 3'd5,
        REQ_FIND   = 3'd6,
        REQ_CLEAR  = 3'd7
    } t_req_type;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 3'd0,
        ERR_POS   = 3'd1,
        ERR_EMPTY = 3'd2,
        ERR_FULL  = 3'd3,
        ERR_MISS  = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        CO_HOLD,
        CO_WRITE,
        CO_SHIFT_UP,
        CO_SHIFT_DOWN
    } t_cell_op;

    // Command broadcast to every cell
    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] lo;   // first index to zero-fill
        logic [IDX_W-1:0] tgt;  // index that takes the new word
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic               ok;
        t_err               err;
        logic [DATA_W-1:0]  data;
        logic [FOUND_W-1:0] found;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

// ===== sv/olec_ifs.sv =====
// Request channel
interface olec_req_if;
    import olec_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface

// Result channel
interface olec_res_if;
    import olec_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [ERR_W-1:0]   error_code;
    logic [DATA_W-1:0]  data_out;
    logic [FOUND_W-1:0] found_position;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, output ok, output error_code, output data_out,
                    output found_position, output entry_count, input ready);
    modport sink   (input valid, input ok, input error_code, input data_out,
                    input found_position, input entry_count, output ready);
endinterface

// ===== sv/ordered_list_engine_core.sv =====
// Channel  | Dir | Beat contents
// ---------+-----+------------------------------------------------------
// i_req    | in  | req_type, position, value
// o_res    | out | ok, error_code, data_out, found_position, entry_count
//
// Get, set, insert, remove, push, pop and clear complete at the accepting edge:
// the cell row updates and the result register loads there.
// Find of a nonzero value scans the per-cell match flags one group of eight per
// cycle, up to ceil(DEPTH/8) groups, and loads the result at the first hit.
// i_rst_n (synchronous, active low) clears the count, the FSM and the output
// valid; entry storage is not cleared.
// A new request is taken only once the previous result beat has left.
`include "ordered_list_engine_core_macros.svh"

module ordered_list_engine_core #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    olec_req_if.sink   i_req,
    olec_res_if.source o_res
);
    import olec_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
    localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int MP_W  = NGRP * GRP;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [GW-1:0]         r_grp, n_grp;
    logic [WORD_WIDTH-1:0] r_key;
    logic                  r_out_valid;
    t_result               r_res, n_res;
    logic                  res_load;
    logic                  go_scan;
    logic                  accept;
    t_cell_cmd             cmd;

    logic [WORD_WIDTH-1:0] w_entry [DEPTH];
    logic [WORD_WIDTH-1:0] w_left  [DEPTH];
    logic [WORD_WIDTH-1:0] w_right [DEPTH];
    logic [DEPTH-1:0]      w_match;
    logic [MP_W-1:0]       match_pad;
    logic [GRP-1:0]        grp_bits;
    logic [GRP_LOG-1:0]    grp_off;
    logic                  grp_hit;

    logic [IDX_W-1:0]      pos_x, pos_m1, cnt_x, cnt_m1, dep_x, found_x;
    logic [WORD_WIDTH-1:0] val_w;
    logic [AW-1:0]         rd_idx;
    logic [WORD_WIDTH-1:0] rd_word;
    t_req_type             req;

    // Handshake
    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign accept      = i_req.valid && i_req.ready;

    // Request decode helpers
    assign req     = t_req_type'(i_req.req_type);
    assign val_w   = WORD_WIDTH'(i_req.value);
    assign pos_x   = IDX_W'(i_req.position);
    assign pos_m1  = pos_x - IDX_W'(1);
    assign cnt_x   = IDX_W'(r_cnt);
    assign cnt_m1  = cnt_x - IDX_W'(1);
    assign dep_x   = IDX_W'(DEPTH);
    assign rd_idx  = (req == REQ_POP) ? cnt_m1[AW-1:0] : pos_m1[AW-1:0];
    assign rd_word = w_entry[rd_idx];

    // Row of cells, each handing its word to both neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_mid_l
            assign w_left[g] = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right[g] = w_entry[g];
        end else begin : g_mid_r
            assign w_right[g] = w_entry[g+1];
        end

        olec_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_value (val_w),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_key   (r_key),
            .i_count (cnt_x),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    // Group of match flags under scan, first hit within it
    assign match_pad = MP_W'(w_match);
    assign grp_bits  = match_pad[r_grp * GRP +: GRP];
    assign grp_hit   = |grp_bits;

    always_comb begin
        grp_off = '0;
        for (int k = GRP - 1; k >= 0; k--) begin
            if (grp_bits[k]) begin
                grp_off = GRP_LOG'(k);
            end
        end
    end

    assign found_x = (IDX_W'(r_grp) << GRP_LOG) + IDX_W'(grp_off) + IDX_W'(1);

    // Controller: next state, cell command and result
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_grp    = r_grp;
        n_res    = '0;
        res_load = 1'b0;
        go_scan  = 1'b0;
        cmd.op   = CO_HOLD;
        cmd.lo   = '0;
        cmd.tgt  = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    res_load  = 1'b1;
                    n_res.err = ERR_NONE;
                    case (req)
                        REQ_GET: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_res.err = ERR_POS;
                            end else begin
                                n_res.data = DATA_W'(rd_word);
                            end
                        end
                        REQ_SET, REQ_INSERT: begin
                            if (pos_x == '0) begin
                                n_res.err = ERR_POS;
                            end else if (pos_x <= cnt_x) begin
                                if (req == REQ_SET) begin
                                    cmd.op     = CO_WRITE;
                                    cmd.lo     = pos_m1;
                                    cmd.tgt    = pos_m1;
                                    n_res.data = DATA_W'(rd_word);
                                end else if (cnt_x >= dep_x) begin
                                    n_res.err = ERR_FULL;
                                end else begin
                                    cmd.op  = CO_SHIFT_UP;
                                    cmd.tgt = pos_m1;
                                    n_cnt   = r_cnt + CNT_W'(1);
                                end
                            end else if (pos_x > dep_x) begin
                                n_res.err = ERR_FULL;
                            end else begin
                                // pad with zeros, then append at the position
                                cmd.op  = CO_WRITE;
                                cmd.lo  = cnt_x;
                                cmd.tgt = pos_m1;
                                n_cnt   = CNT_W'(pos_x);
                            end
                        end
                        REQ_REMOVE: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_res.err = ERR_POS;
                            end else begin
                                cmd.op     = CO_SHIFT_DOWN;
                                cmd.tgt    = pos_m1;
                                n_res.data = DATA_W'(rd_word);
                                n_cnt      = r_cnt - CNT_W'(1);
                            end
                        end
                        REQ_PUSH: begin
                            if (cnt_x >= dep_x) begin
                                n_res.err = ERR_FULL;
                            end else begin
                                cmd.op  = CO_WRITE;
                                cmd.lo  = cnt_x;
                                cmd.tgt = cnt_x;
                                n_cnt   = r_cnt + CNT_W'(1);
                            end
                        end
                        REQ_POP: begin
                            if (cnt_x == '0) begin
                                n_res.err = ERR_EMPTY;
                            end else begin
                                n_res.data = DATA_W'(rd_word);
                                n_cnt      = r_cnt - CNT_W'(1);
                            end
                        end
                        REQ_FIND: begin
                            if (val_w == '0) begin
                                n_res.err = ERR_MISS;
                            end else begin
                                res_load = 1'b0;
                                go_scan  = 1'b1;
                                n_grp    = '0;
                                n_state  = S_SCAN;
                            end
                        end
                        REQ_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                            n_res.err = ERR_NONE;
                        end
                    endcase
                    n_res.ok    = (n_res.err == ERR_NONE);
                    n_res.count = COUNT_W'(n_cnt);
                end
            end
            S_SCAN: begin
                n_res.count = COUNT_W'(r_cnt);
                if (grp_hit) begin
                    res_load    = 1'b1;
                    n_res.ok    = 1'b1;
                    n_res.err   = ERR_NONE;
                    n_res.found = FOUND_W'(found_x);
                    n_state     = S_IDLE;
                end else if (r_grp == GW'(NGRP - 1)) begin
                    res_load  = 1'b1;
                    n_res.err = ERR_MISS;
                    n_state   = S_IDLE;
                end else begin
                    n_grp = r_grp + GW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, count and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_grp   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_grp   <= n_grp;
        end
    end

    // Search key held for the scan
    always_ff @(posedge i_clk) begin
        if (go_scan) begin
            r_key <= val_w;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.ok             = r_res.ok;
    assign o_res.error_code     = r_res.err;
    assign o_res.data_out       = r_res.data;
    assign o_res.found_position = r_res.found;
    assign o_res.entry_count    = r_res.count;

    // Checks
    `OLEC_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(DEPTH), "count past DEPTH")
    `OLEC_ASSERT_NOW(a_scan_range, r_state == S_SCAN, r_grp <= GW'(NGRP - 1), "scan overrun")
    `OLEC_ASSERT_NEXT(a_one_cycle, accept && !go_scan, r_out_valid, "result beat missing")
    `OLEC_ASSERT_NOW(a_ok_code, r_out_valid, r_res.ok == (r_res.err == ERR_NONE), "ok mismatch")

endmodule

// ===== sv/olec_cell.sv =====
module olec_cell #(
    parameter int WORD_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                      i_clk,
    input  olec_pkg::t_cell_cmd       i_cmd,
    input  logic [WORD_WIDTH-1:0]     i_value,
    input  logic [WORD_WIDTH-1:0]     i_left,
    input  logic [WORD_WIDTH-1:0]     i_right,
    input  logic [WORD_WIDTH-1:0]     i_key,
    input  logic [olec_pkg::IDX_W-1:0] i_count,
    output logic [WORD_WIDTH-1:0]     o_entry,
    output logic                      o_match
);
    import olec_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [WORD_WIDTH-1:0] r_entry;
    logic [WORD_WIDTH-1:0] n_entry;

    // Entry update: load, zero-fill, or take a neighbor's word
    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            CO_WRITE: begin
                if (MY_IDX == i_cmd.tgt) begin
                    n_entry = i_value;
                end else if (MY_IDX >= i_cmd.lo && MY_IDX < i_cmd.tgt) begin
                    n_entry = '0;
                end
            end
            CO_SHIFT_UP: begin
                if (MY_IDX == i_cmd.tgt) begin
                    n_entry = i_value;
                end else if (MY_IDX > i_cmd.tgt) begin
                    n_entry = i_left;
                end
            end
            CO_SHIFT_DOWN: begin
                if (MY_IDX >= i_cmd.tgt) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    // Only live entries can match
    assign o_match = (r_entry == i_key) && (MY_IDX < i_count);

endmodule
